// ===== hdl/meta_entry_bit_encoder_macros.svh =====
// Assertion macros for the meta entry bit encoder.
`ifndef META_ENTRY_BIT_ENCODER_MACROS_SVH
`define META_ENTRY_BIT_ENCODER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define MEB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define MEB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MEB_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define MEB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/meb_pkg.sv =====
// Types and constants shared by the meta entry bit encoder modules.
package meb_pkg;

    localparam int MAX_FIELD_WIDTH = 32;
    localparam int FIELD_W         = 32;
    localparam int WORD_W          = 64;
    localparam int STR_W           = 192;
    localparam int VARINT_BYTES    = 10;
    localparam int VARINT_W        = 80;
    localparam int CFG_W           = 6;
    localparam int CFG_IDX_W       = 2;
    localparam int LEN_W           = 8;
    localparam int WNUM_W          = 2;

    // Queue between the front and back ends; depth must be a power of two.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MID_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUTER_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INSERT_WIDTH = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] RST_MID_WIDTH    = 6'd1;
    localparam logic [CFG_W-1:0] RST_ROUTER_WIDTH = 6'd16;
    localparam logic [CFG_W-1:0] RST_INSERT_WIDTH = 6'd8;

    typedef struct packed {
        logic signed [63:0] offset;
        logic [FIELD_W-1:0] mid_value;
        logic [FIELD_W-1:0] router_value;
        logic [FIELD_W-1:0] insert_value;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] packed_word;
        logic [WNUM_W-1:0] word_number;
        logic [LEN_W-1:0]  bit_length;
        logic              last_word;
    } t_out_item;

    // One classified entry: varint image, masked fields and bit positions.
    typedef struct packed {
        logic [VARINT_W-1:0] varint;
        logic [FIELD_W-1:0]  mid_field;
        logic [FIELD_W-1:0]  router_field;
        logic [FIELD_W-1:0]  insert_field;
        logic [LEN_W-1:0]    mid_pos;
        logic [LEN_W-1:0]    router_pos;
        logic [LEN_W-1:0]    insert_pos;
        logic [LEN_W-1:0]    bit_length;
        logic [WNUM_W-1:0]   last_index;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== hdl/meta_entry_bit_encoder.sv =====
// Top level of the meta entry bit encoder: front end, queue and back end.
//
//   Channel   Direction  Handshake          Payload
//   input     in         push / full        i_item   (t_in_item)
//   result    out        empty / pop        o_result (t_out_item), 1 to 3 per entry
//   config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// An entry yields one result word per cycle while pop is held high, so it occupies
// the back end for one to three words depending on its bit length; the front end takes a new
// entry every cycle while the two-entry queue has room.
// An input entry passes the front-stage register and the queue into the result register.
// Reset is synchronous and active low and empties the front stage, queue and
// result register; configuration registers return to 1, 16 and 8.
// Either side may stall independently; a held result leaves its word in place.
`include "meta_entry_bit_encoder_macros.svh"
module meta_entry_bit_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [meb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [meb_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  meb_pkg::t_in_item             i_item,
    output logic                          empty,
    input  logic                          pop,
    output meb_pkg::t_out_item            o_result
);
    import meb_pkg::*;

    t_q_entry  front_entry;
    t_q_entry  queue_entry;
    t_q_status q_status;
    logic      q_push;
    logic      q_pop;

    // Classifies each entry and computes its bit positions.
    meb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .i_q_status (q_status),
        .o_q_push   (q_push),
        .o_q_entry  (front_entry)
    );

    // Decouples the two ends.
    meb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_entry  (front_entry),
        .i_pop    (q_pop),
        .o_entry  (queue_entry),
        .o_status (q_status)
    );

    // Builds the string and hands out its words.
    meb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (queue_entry),
        .i_q_status (q_status),
        .o_q_pop    (q_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (o_result)
    );

    // A word that is not the last must leave string bits for a later word.
    `MEB_ASSERT_IMPLIES(a_not_last_len, !empty && !o_result.last_word, ({1'b0, o_result.bit_length} > ((9'(o_result.word_number) + 9'd1) << 6)), "word marked not last but string ends here")
    // The last word must still hold string bits.
    `MEB_ASSERT_IMPLIES(a_last_len, !empty && o_result.last_word, ({1'b0, o_result.bit_length} > (9'(o_result.word_number) << 6)), "last word lies past the end of the string")
    // After a word that is not the last transfers, the next word follows.
    `MEB_ASSERT_NEXT(a_word_step, pop && !empty && !o_result.last_word, !empty && (o_result.word_number == $past(o_result.word_number) + 2'd1), "word sequence broken within an entry")

endmodule

// ===== hdl/meb_front.sv =====
// Front end: configuration registers, zigzag varint coding and field placement.
module meb_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [meb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [meb_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_push,
    output logic                       o_full,
    input  meb_pkg::t_in_item          i_item,
    input  meb_pkg::t_q_status         i_q_status,
    output logic                       o_q_push,
    output meb_pkg::t_q_entry          o_q_entry
);
    import meb_pkg::*;

    logic [CFG_W-1:0]    r_mid_w, r_router_w, r_insert_w;
    logic [CFG_W-1:0]    cfg_clamped;
    logic                r_valid;
    t_q_entry            r_entry;
    t_q_entry            n_entry;
    logic                advance;
    logic [63:0]         zz;
    logic [VARINT_W-1:0] zz_ext;
    logic [VARINT_BYTES-1:0] nz;
    logic [3:0]          nbytes;
    logic [VARINT_W-1:0] varint;

    // Widths above the field size saturate when written.
    assign cfg_clamped = (i_cfg_data > CFG_W'(MAX_FIELD_WIDTH)) ?
                         CFG_W'(MAX_FIELD_WIDTH) : i_cfg_data;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_w    <= RST_MID_WIDTH;
            r_router_w <= RST_ROUTER_WIDTH;
            r_insert_w <= RST_INSERT_WIDTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MID_WIDTH:    r_mid_w    <= cfg_clamped;
                REG_ROUTER_WIDTH: r_router_w <= cfg_clamped;
                REG_INSERT_WIDTH: r_insert_w <= cfg_clamped;
                default: ;
            endcase
        end
    end

    // Zigzag map and split into 7-bit groups.
    assign zz     = {i_item.offset[62:0], 1'b0} ^ {64{i_item.offset[63]}};
    assign zz_ext = VARINT_W'(zz);

    // Byte count from the highest nonzero group, then the byte image.
    always_comb begin
        for (int j = 0; j < VARINT_BYTES; j++) begin
            nz[j] = |zz_ext[7*j +: 7];
        end
        nbytes = 4'd1;
        for (int j = 1; j < VARINT_BYTES; j++) begin
            if (nz[j]) begin
                nbytes = 4'(j + 1);
            end
        end
        for (int j = 0; j < VARINT_BYTES; j++) begin
            varint[8*j +: 8] = {(4'(j + 1) < nbytes), zz_ext[7*j +: 7]};
        end
    end

    // Field masks and bit positions of each part of the string.
    always_comb begin
        n_entry.varint       = varint;
        n_entry.mid_field    = i_item.mid_value &
                               FIELD_W'((33'd1 << r_mid_w) - 33'd1);
        n_entry.router_field = i_item.router_value &
                               FIELD_W'((33'd1 << r_router_w) - 33'd1);
        n_entry.insert_field = i_item.insert_value &
                               FIELD_W'((33'd1 << r_insert_w) - 33'd1);
        n_entry.mid_pos      = {1'b0, nbytes, 3'b000};
        n_entry.router_pos   = n_entry.mid_pos + LEN_W'(r_mid_w);
        n_entry.insert_pos   = n_entry.router_pos + LEN_W'(r_router_w);
        n_entry.bit_length   = n_entry.insert_pos + LEN_W'(r_insert_w);
        n_entry.last_index   = WNUM_W'((n_entry.bit_length - 8'd1) >> 6);
    end

    // The stage moves on when empty or when the queue takes its entry.
    assign advance  = !r_valid || !i_q_status.full;
    assign o_full   = !advance;
    assign o_q_push = r_valid && !i_q_status.full;
    assign o_q_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_push) begin
            r_entry <= n_entry;
        end
    end

endmodule

// ===== hdl/meb_queue.sv =====
// Short queue of classified entries between the front and back ends.
module meb_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  meb_pkg::t_q_entry  i_entry,
    input  logic               i_pop,
    output meb_pkg::t_q_entry  o_entry,
    output meb_pkg::t_q_status o_status
);
    import meb_pkg::*;

    t_q_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr, r_rd;
    logic [Q_CNT_W-1:0]   r_cnt;
    logic                 do_push, do_pop;

    assign o_status.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_entry = r_mem[r_rd];

    // Pointers and fill count; pointers wrap at the power-of-two depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// ===== hdl/meb_back.sv =====
// Back end: assembles the bit string and hands it out one word per transfer.
module meb_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  meb_pkg::t_q_entry   i_entry,
    input  meb_pkg::t_q_status  i_q_status,
    output logic                o_q_pop,
    output logic                o_empty,
    input  logic                i_pop,
    output meb_pkg::t_out_item  o_result
);
    import meb_pkg::*;

    logic                r_valid;
    logic [STR_W-1:0]    r_str;
    logic [STR_W-1:0]    n_str;
    logic [WNUM_W-1:0]   r_k;
    logic [WNUM_W-1:0]   r_last_k;
    logic [LEN_W-1:0]    r_len;
    logic                is_last;
    logic                load;

    // Place the varint and the three fields at their bit positions.
    assign n_str = STR_W'(i_entry.varint)
                 | (STR_W'(i_entry.mid_field)    << i_entry.mid_pos)
                 | (STR_W'(i_entry.router_field) << i_entry.router_pos)
                 | (STR_W'(i_entry.insert_field) << i_entry.insert_pos);

    assign is_last = (r_k == r_last_k);
    assign load    = !i_q_status.empty && (!r_valid || (i_pop && is_last));
    assign o_q_pop = load;
    assign o_empty = !r_valid;

    // Word select for the current result.
    always_comb begin
        unique case (r_k)
            2'd0:    o_result.packed_word = r_str[0 +: WORD_W];
            2'd1:    o_result.packed_word = r_str[WORD_W +: WORD_W];
            2'd2:    o_result.packed_word = r_str[2*WORD_W +: WORD_W];
            default: o_result.packed_word = '0;
        endcase
        o_result.word_number = r_k;
        o_result.bit_length  = r_len;
        o_result.last_word   = is_last;
    end

    // Word sequencing: a new entry loads as the last word transfers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_k     <= '0;
        end else if (i_pop && r_valid) begin
            if (is_last) begin
                r_valid <= 1'b0;
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_str    <= n_str;
            r_last_k <= i_entry.last_index;
            r_len    <= i_entry.bit_length;
        end
    end

endmodule
